>>> rtl/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, register map, reset values and arithmetic constants for the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

  localparam int SPEED_W     = 16;
  localparam int ANGLE_W     = 16;
  localparam int TRIG_W      = 32;
  localparam int REG_W       = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int OUT_POS_W   = 32;
  localparam int ATAN_W      = 30;
  localparam int ATAN_IDX_W  = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INV_WHEEL_BASE = 3'd0,
    CFG_TICK_PERIOD    = 3'd1,
    CFG_START_X        = 3'd2,
    CFG_START_Y        = 3'd3,
    CFG_START_HEADING  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE,
    S_TURN,
    S_SCALE,
    S_HEAD,
    S_ROT,
    S_MOVE1,
    S_MOVE2,
    S_ACC
  } state_t;

  localparam logic [REG_W-1:0]          IWB_RESET           = 16'd9102;
  localparam logic [REG_W-1:0]          TP_RESET            = 16'd6554;
  localparam logic signed [OUT_POS_W-1:0] START_X_RESET     = 32'sd0;
  localparam logic signed [OUT_POS_W-1:0] START_Y_RESET     = 32'sd0;
  localparam logic [ANGLE_W-1:0]        START_HEADING_RESET = 16'd0;

  // 65536 / (2*pi) in Q14
  localparam logic [27:0]               TURN_SCALE   = 28'd170891319;
  // CORDIC gain compensation, Q30
  localparam logic signed [TRIG_W-1:0]  CORDIC_START = 32'sd652032874;

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/odo_if.sv
// ----------------------------------------------------------------------------
// odo_if
// Valid/ready channels of the odometry block: wheel speeds in, pose out.
// ----------------------------------------------------------------------------
`default_nettype none

interface odo_wheel_if;
  logic                                valid;
  logic                                ready;
  logic signed [odo_pkg::SPEED_W-1:0]  left_speed;
  logic signed [odo_pkg::SPEED_W-1:0]  right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

interface odo_pose_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [odo_pkg::OUT_POS_W-1:0] pose_x;
  logic signed [odo_pkg::OUT_POS_W-1:0] pose_y;
  logic [odo_pkg::ANGLE_W-1:0]          pose_heading;

  modport source (output valid, output pose_x, output pose_y, output pose_heading,
                  input ready);
  modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/odo_serial_mul.sv
// ----------------------------------------------------------------------------
// odo_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle. Stops as soon
// as the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_serial_mul #(
  parameter int A_W = 33,
  parameter int B_W = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic                 busy,
  output logic [A_W+B_W-1:0]   prod
);

  localparam int P_W = A_W + B_W;

  logic [P_W-1:0] acc;
  logic [P_W-1:0] mcand;
  logic [B_W-1:0] mplier;

  assign busy = |mplier;
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (load) begin
      mplier <= b;
    end else if (busy) begin
      mplier <= mplier >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc   <= '0;
      mcand <= P_W'(a);
    end else if (busy) begin
      acc   <= acc + (mplier[0] ? mcand : '0);
      mcand <= mcand << 1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/odo_cordic.sv
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC: cosine and sine (Q30) of a 16-bit binary
// angle, one micro-rotation per cycle, quadrant folded in at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [odo_pkg::ANGLE_W-1:0]         angle,
  output logic                                busy,
  output logic signed [odo_pkg::TRIG_W-1:0]   cos_q30,
  output logic signed [odo_pkg::TRIG_W-1:0]   sin_q30
);

  localparam int CNT_W = $clog2(STEPS);
  localparam int TW    = odo_pkg::TRIG_W;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  logic                   run;
  logic [CNT_W-1:0]       cnt;
  logic [1:0]             quad;
  logic signed [TW-1:0]   x;
  logic signed [TW-1:0]   y;
  logic signed [TW-1:0]   z;
  logic signed [TW-1:0]   xs;
  logic signed [TW-1:0]   ys;
  logic signed [TW-1:0]   step_ang;

  assign busy     = run;
  // arithmetic shift is a floor shift
  assign xs       = x >>> cnt;
  assign ys       = y >>> cnt;
  assign step_ang = signed'(TW'(odo_pkg::atan_turn(odo_pkg::ATAN_IDX_W'(cnt))));

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      if (cnt == CNT_W'(STEPS - 1)) begin
        run <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= odo_pkg::CORDIC_START;
      y    <= '0;
      // remainder within the quadrant, as a 32-bit turn fraction
      z    <= signed'({2'b00, angle[odo_pkg::ANGLE_W-3:0], 16'h0000});
      quad <= angle[odo_pkg::ANGLE_W-1:odo_pkg::ANGLE_W-2];
    end else if (run) begin
      if (!z[TW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step_ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step_ang;
      end
    end
  end

  always_comb begin
    case (quad)
      QUAD_I: begin
        cos_q30 = x;
        sin_q30 = y;
      end
      QUAD_II: begin
        cos_q30 = -y;
        sin_q30 = x;
      end
      QUAD_III: begin
        cos_q30 = -x;
        sin_q30 = -y;
      end
      default: begin
        cos_q30 = y;
        sin_q30 = -x;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose integrator for a two-wheel robot.
//
// wheels: one word per control tick, left and right speed (Q4.12 m/s).
// pose:   one word per tick, new x, y (Q16.16 m, saturating) and heading.
// cfg:    write-only register port (cfg_wr_en, cfg_index, cfg_data); write
//         only while no tick is in flight.
// One tick at a time: wheels.ready is high only while idle. A tick runs
// through bit-serial shift-add multipliers and an iterative CORDIC, so the
// time from accept to pose.valid is shorter when the operands have fewer
// significant bits; the multiplier bit lengths and the CORDIC step count
// set it.
// The next tick may be accepted while a pose word waits; it finishes all
// arithmetic and holds just before updating the pose until pose.ready.
// Reset puts the pose at the start-register reset values and clears all
// handshakes; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry #(
  parameter int CORDIC_STEPS   = 16,
  parameter int POSITION_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [odo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [odo_pkg::CFG_DATA_W-1:0]     cfg_data,
  odo_wheel_if.sink                          wheels,
  odo_pose_if.source                         pose
);

  localparam int PW     = POSITION_WIDTH;
  localparam int RW     = odo_pkg::REG_W;
  localparam int AW     = odo_pkg::ANGLE_W;
  localparam int TW     = odo_pkg::TRIG_W;
  localparam int SW     = odo_pkg::SPEED_W;
  // turn chain multiplier
  localparam int TA_W   = 33;
  localparam int TB_W   = 28;
  localparam int TP_W   = TA_W + TB_W;
  // position multipliers
  localparam int MA_W   = 48;
  localparam int MB_W   = SW + 1;
  localparam int MP_W   = MA_W + MB_W;
  localparam int DXM_W  = 22;

  odo_pkg::state_t state;
  odo_pkg::state_t state_next;

  logic [RW-1:0]            iwb;
  logic [RW-1:0]            tp;

  logic signed [PW-1:0]     pos_x;
  logic signed [PW-1:0]     pos_y;
  logic [AW-1:0]            heading;
  logic [AW-1:0]            hd_new;
  logic [AW-1:0]            hd_sum;
  logic [AW-1:0]            units;
  logic                     out_valid;
  logic                     commit;

  logic [SW:0]              diff17;
  logic [SW:0]              diff_abs;
  logic [SW:0]              lin17;
  logic [SW:0]              lin_abs;
  logic [MB_W-1:0]          lin_mag;
  logic                     lin_neg;
  logic                     turn_neg;

  logic                     t_load;
  logic [TA_W-1:0]          t_a;
  logic [TB_W-1:0]          t_b;
  logic                     t_busy;
  logic [TP_W-1:0]          t_prod;
  logic [48:0]              d_sum;
  logic [53:0]              u_sum;
  logic [AW-1:0]            u16;

  logic                     c_start;
  logic                     c_busy;
  logic signed [TW-1:0]     c_cos;
  logic signed [TW-1:0]     c_sin;
  logic [TW-1:0]            cos_abs;
  logic [TW-1:0]            sin_abs;

  logic                     m_load;
  logic [MA_W-1:0]          xa;
  logic [MA_W-1:0]          ya;
  logic [MB_W-1:0]          m_b;
  logic                     x_busy;
  logic                     y_busy;
  logic [MP_W-1:0]          x_prod;
  logic [MP_W-1:0]          y_prod;
  logic                     x_neg;
  logic                     y_neg;
  logic [64:0]              dx_sum;
  logic [64:0]              dy_sum;
  logic signed [DXM_W:0]    dx;
  logic signed [DXM_W:0]    dy;

  function automatic logic signed [PW-1:0] sat_add(input logic signed [PW-1:0] p,
                                                   input logic signed [DXM_W:0] d);
    logic signed [PW:0] s;
    s = (PW+1)'(p) + (PW+1)'(d);
    if (s[PW] != s[PW-1]) begin
      return s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end
    return s[PW-1:0];
  endfunction

  odo_serial_mul #(.A_W(TA_W), .B_W(TB_W)) u_turn_mul (
    .clk  (clk),
    .rst  (rst),
    .load (t_load),
    .a    (t_a),
    .b    (t_b),
    .busy (t_busy),
    .prod (t_prod)
  );

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (c_start),
    .angle   (hd_sum),
    .busy    (c_busy),
    .cos_q30 (c_cos),
    .sin_q30 (c_sin)
  );

  odo_serial_mul #(.A_W(MA_W), .B_W(MB_W)) u_x_mul (
    .clk  (clk),
    .rst  (rst),
    .load (m_load),
    .a    (xa),
    .b    (m_b),
    .busy (x_busy),
    .prod (x_prod)
  );

  odo_serial_mul #(.A_W(MA_W), .B_W(MB_W)) u_y_mul (
    .clk  (clk),
    .rst  (rst),
    .load (m_load),
    .a    (ya),
    .b    (m_b),
    .busy (y_busy),
    .prod (y_prod)
  );

  // sign-magnitude arithmetic: rounding half away from zero is a plain
  // round-half-up of the magnitude
  assign diff17   = {wheels.right_speed[SW-1], wheels.right_speed}
                  - {wheels.left_speed[SW-1], wheels.left_speed};
  assign diff_abs = diff17[SW] ? -diff17 : diff17;
  assign lin17    = {wheels.left_speed[SW-1], wheels.left_speed}
                  + {wheels.right_speed[SW-1], wheels.right_speed};
  assign lin_abs  = lin17[SW] ? -lin17 : lin17;

  // Q.40 rad -> Q.24 rad, then Q.38 turn units -> whole units
  assign d_sum    = {1'b0, t_prod[47:0]} + (49'd1 << 15);
  assign u_sum    = t_prod[53:0] + (54'd1 << 37);
  assign u16      = u_sum[53:38];
  assign hd_sum   = heading + units;

  assign cos_abs  = c_cos[TW-1] ? -c_cos : c_cos;
  assign sin_abs  = c_sin[TW-1] ? -c_sin : c_sin;

  assign dx_sum   = {1'b0, x_prod[63:0]} + (65'd1 << 42);
  assign dy_sum   = {1'b0, y_prod[63:0]} + (65'd1 << 42);

  assign wheels.ready      = (state == odo_pkg::S_IDLE);
  assign pose.valid        = out_valid;
  assign pose.pose_x       = odo_pkg::OUT_POS_W'(pos_x);
  assign pose.pose_y       = odo_pkg::OUT_POS_W'(pos_y);
  assign pose.pose_heading = heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= odo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    t_load     = 1'b0;
    t_a        = '0;
    t_b        = '0;
    c_start    = 1'b0;
    m_load     = 1'b0;
    xa         = '0;
    ya         = '0;
    m_b        = '0;
    commit     = 1'b0;
    case (state)
      odo_pkg::S_IDLE: begin
        if (wheels.valid) begin
          t_load     = 1'b1;
          t_a        = TA_W'(diff_abs[SW-1:0]);
          t_b        = TB_W'(iwb);
          state_next = odo_pkg::S_RATE;
        end
      end
      odo_pkg::S_RATE: begin
        if (!t_busy) begin
          t_load     = 1'b1;
          t_a        = t_prod[TA_W-1:0];
          t_b        = TB_W'(tp);
          state_next = odo_pkg::S_TURN;
        end
      end
      odo_pkg::S_TURN: begin
        if (!t_busy) begin
          t_load     = 1'b1;
          t_a        = d_sum[48:16];
          t_b        = odo_pkg::TURN_SCALE;
          state_next = odo_pkg::S_SCALE;
        end
      end
      odo_pkg::S_SCALE: begin
        if (!t_busy) begin
          state_next = odo_pkg::S_HEAD;
        end
      end
      odo_pkg::S_HEAD: begin
        c_start    = 1'b1;
        state_next = odo_pkg::S_ROT;
      end
      odo_pkg::S_ROT: begin
        if (!c_busy) begin
          m_load     = 1'b1;
          xa         = MA_W'(cos_abs);
          ya         = MA_W'(sin_abs);
          m_b        = lin_mag;
          state_next = odo_pkg::S_MOVE1;
        end
      end
      odo_pkg::S_MOVE1: begin
        if (!x_busy && !y_busy) begin
          m_load     = 1'b1;
          xa         = x_prod[MA_W-1:0];
          ya         = y_prod[MA_W-1:0];
          m_b        = MB_W'(tp);
          state_next = odo_pkg::S_MOVE2;
        end
      end
      odo_pkg::S_MOVE2: begin
        if (!x_busy && !y_busy) begin
          state_next = odo_pkg::S_ACC;
        end
      end
      odo_pkg::S_ACC: begin
        // pose registers feed the output word, so wait for it to drain
        if (!out_valid || pose.ready) begin
          commit     = 1'b1;
          state_next = odo_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = odo_pkg::S_IDLE;
      end
    endcase
  end

  // Start registers only matter at reset, and reset restores them too, so
  // the pose always restarts from their reset values; writes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      iwb <= odo_pkg::IWB_RESET;
      tp  <= odo_pkg::TP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        odo_pkg::CFG_INV_WHEEL_BASE: iwb <= cfg_data[RW-1:0];
        odo_pkg::CFG_TICK_PERIOD:    tp  <= cfg_data[RW-1:0];
        odo_pkg::CFG_START_X,
        odo_pkg::CFG_START_Y,
        odo_pkg::CFG_START_HEADING: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= PW'(odo_pkg::START_X_RESET);
      pos_y     <= PW'(odo_pkg::START_Y_RESET);
      heading   <= odo_pkg::START_HEADING_RESET;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        pos_x   <= sat_add(pos_x, dx);
        pos_y   <= sat_add(pos_y, dy);
        heading <= hd_new;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (pose.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == odo_pkg::S_IDLE && wheels.valid) begin
      lin_mag  <= lin_abs;
      lin_neg  <= lin17[SW];
      turn_neg <= diff17[SW];
    end
    if (state == odo_pkg::S_SCALE && !t_busy) begin
      units <= turn_neg ? -u16 : u16;
    end
    if (state == odo_pkg::S_HEAD) begin
      hd_new <= hd_sum;
    end
    if (state == odo_pkg::S_ROT && !c_busy) begin
      x_neg <= lin_neg ^ c_cos[TW-1];
      y_neg <= lin_neg ^ c_sin[TW-1];
    end
    if (state == odo_pkg::S_MOVE2 && !x_busy && !y_busy) begin
      dx <= x_neg ? -signed'({1'b0, dx_sum[64:43]}) : signed'({1'b0, dx_sum[64:43]});
      dy <= y_neg ? -signed'({1'b0, dy_sum[64:43]}) : signed'({1'b0, dy_sum[64:43]});
    end
  end

`ifndef SYNTH
  a_pose_held: assert property (@(posedge clk) disable iff (rst)
    (state == odo_pkg::S_ACC && out_valid && !pose.ready) |=> state == odo_pkg::S_ACC)
    else $error("pose updated while previous word still pending");

  a_cordic_phase: assert property (@(posedge clk) disable iff (rst)
    c_busy |-> state == odo_pkg::S_ROT)
    else $error("CORDIC running outside rotation phase");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == odo_pkg::S_IDLE |-> (!t_busy && !x_busy && !y_busy && !c_busy))
    else $error("arithmetic unit busy while idle");
`endif

endmodule

`default_nettype wire
